// File: hdl/chacha20_block_function_unit_defines.svh
// Assertion macros for the ChaCha20 block function checker.
`ifndef CHACHA20_BLOCK_FUNCTION_UNIT_DEFINES_SVH
`define CHACHA20_BLOCK_FUNCTION_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low.
`define CHACHA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off while rst_ni is low.
`define CHACHA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/chacha_pkg.sv
// Shared types and constants for the ChaCha20 block function pipeline.
package chacha_pkg;

  localparam int unsigned WORD_W       = 32;
  localparam int unsigned NUM_WORDS    = 16;
  localparam int unsigned STEPS_PER_DR = 8;  // four quarter-round steps on the columns, then four on the diagonals

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [NUM_WORDS-1:0] state_t;

  // Payload carried down the cell chain: working state plus the original input.
  typedef struct packed {
    state_t work;
    state_t init;
  } stage_t;

endpackage

// File: hdl/chacha_ifs.sv
// Valid/ready channel interfaces for input state beats and keystream beats.
interface chacha_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] words_0_1;
  logic [63:0] words_2_3;
  logic [63:0] words_4_5;
  logic [63:0] words_6_7;
  logic [63:0] words_8_9;
  logic [63:0] words_10_11;
  logic [63:0] words_12_13;
  logic [63:0] words_14_15;

  modport source (
    output valid, words_0_1, words_2_3, words_4_5, words_6_7,
           words_8_9, words_10_11, words_12_13, words_14_15,
    input  ready
  );
  modport sink (
    input  valid, words_0_1, words_2_3, words_4_5, words_6_7,
           words_8_9, words_10_11, words_12_13, words_14_15,
    output ready
  );
endinterface

interface chacha_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_0_1;
  logic [63:0] out_2_3;
  logic [63:0] out_4_5;
  logic [63:0] out_6_7;
  logic [63:0] out_8_9;
  logic [63:0] out_10_11;
  logic [63:0] out_12_13;
  logic [63:0] out_14_15;

  modport source (
    output valid, out_0_1, out_2_3, out_4_5, out_6_7,
           out_8_9, out_10_11, out_12_13, out_14_15,
    input  ready
  );
  modport sink (
    input  valid, out_0_1, out_2_3, out_4_5, out_6_7,
           out_8_9, out_10_11, out_12_13, out_14_15,
    output ready
  );
endinterface

// File: hdl/chacha_qr_cell.sv
// One pipeline cell: one add/xor/rotate step of four parallel quarter-rounds.
module chacha_qr_cell #(
  parameter int unsigned STEP = 0  // position within the double round, 0..7
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  chacha_pkg::stage_t data_i,
  output logic               valid_o,
  output chacha_pkg::stage_t data_o
);
  import chacha_pkg::*;

  localparam bit          DIAG = (STEP >= 4);
  localparam int unsigned K    = STEP % 4;
  // roles: a=0 b=1 c=2 d=3; even steps a+=b, d^=a; odd steps c+=d, b^=c
  localparam int unsigned P    = (K % 2 == 0) ? 0 : 2;
  localparam int unsigned Q    = (K % 2 == 0) ? 1 : 3;
  localparam int unsigned R    = (K % 2 == 0) ? 3 : 1;
  localparam int unsigned ROT  = (K == 0) ? 16 : (K == 1) ? 12 : (K == 2) ? 8 : 7;

  logic   valid_q;
  stage_t data_q;
  state_t work_d;

  function automatic logic [3:0] qr_idx(input int unsigned j, input int unsigned role);
    int unsigned col;
    col = DIAG ? ((j + role) % 4) : j;
    return 4'(role * 4 + col);
  endfunction

  function automatic word_t rotl32(input word_t v, input int unsigned n);
    return (v << n) | (v >> (WORD_W - n));
  endfunction

  always_comb begin
    word_t sum;
    work_d = data_i.work;
    sum    = '0;
    for (int unsigned j = 0; j < 4; j++) begin
      sum = data_i.work[qr_idx(j, P)] + data_i.work[qr_idx(j, Q)];
      work_d[qr_idx(j, P)] = sum;
      work_d[qr_idx(j, R)] = rotl32(data_i.work[qr_idx(j, R)] ^ sum, ROT);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q.work <= work_d;
      data_q.init <= data_i.init;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: hdl/chacha_out_skid.sv
// Feed-forward add of the input state, then output register plus skid slot.
module chacha_out_skid (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  chacha_pkg::stage_t data_i,
  output logic               ready_o,
  output logic               valid_o,
  input  logic               ready_i,
  output chacha_pkg::state_t data_o
);
  import chacha_pkg::*;

  logic   out_valid_q, out_valid_d;
  logic   skid_valid_q, skid_valid_d;
  state_t out_data_q, out_data_d;
  state_t skid_data_q, skid_data_d;
  state_t fin;
  logic   take;

  always_comb begin
    for (int unsigned i = 0; i < NUM_WORDS; i++) begin
      fin[i] = data_i.work[i] + data_i.init[i];
    end
  end

  assign take = valid_i && !skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (!out_valid_q || ready_i) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = take;
        if (take) begin
          out_data_d = fin;
        end
      end
    end else if (take) begin
      skid_valid_d = 1'b1;
      skid_data_d  = fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign ready_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_data_q;

endmodule

// File: hdl/chacha20_block_function_unit.sv
// ChaCha20 block function (RFC 8439): one 16-word state beat in, one keystream beat out.
// The block is a chain of 8*DOUBLE_ROUNDS cells; each cell holds one state beat and
// performs one add/xor/rotate step on all four quarter-rounds at once, handing its
// result to the next cell every cycle unless the chain holds.  Steps 0..3 of a double
// round work the columns, steps 4..7 the diagonals.  The original input rides along
// with each beat so that a final stage can add it back word by word.  A new state beat
// is accepted every cycle while blk_i.ready is high; it passes the cell chain, then the
// output register.  Behind the output register sits a one-beat skid slot; blk_i.ready
// is low only while that slot is full, and then the whole chain holds.  Each beat is
// independent; nothing is kept between beats and reset only clears the valid bits.
module chacha20_block_function_unit #(
  parameter int unsigned DOUBLE_ROUNDS = 10  // 1..16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  chacha_in_if.sink    blk_i,
  chacha_out_if.source ks_o
);
  import chacha_pkg::*;

  localparam int unsigned NUM_CELLS = STEPS_PER_DR * DOUBLE_ROUNDS;

  // chain taps: index 0 is the input, index NUM_CELLS the last cell's register
  logic   pipe_valid [NUM_CELLS+1];
  stage_t pipe_data  [NUM_CELLS+1];
  state_t in_state;
  state_t ks_state;
  logic   pipe_en;  // whole chain advances together

  // unpack: low word of each field is the even state word
  assign {in_state[1],  in_state[0]}  = blk_i.words_0_1;
  assign {in_state[3],  in_state[2]}  = blk_i.words_2_3;
  assign {in_state[5],  in_state[4]}  = blk_i.words_4_5;
  assign {in_state[7],  in_state[6]}  = blk_i.words_6_7;
  assign {in_state[9],  in_state[8]}  = blk_i.words_8_9;
  assign {in_state[11], in_state[10]} = blk_i.words_10_11;
  assign {in_state[13], in_state[12]} = blk_i.words_12_13;
  assign {in_state[15], in_state[14]} = blk_i.words_14_15;

  assign pipe_valid[0]     = blk_i.valid;
  assign pipe_data[0].work = in_state;
  assign pipe_data[0].init = in_state;
  assign blk_i.ready       = pipe_en;

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    chacha_qr_cell #(
      .STEP (i % STEPS_PER_DR)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (pipe_en),
      .valid_i (pipe_valid[i]),
      .data_i  (pipe_data[i]),
      .valid_o (pipe_valid[i+1]),
      .data_o  (pipe_data[i+1])
    );
  end

  // feed-forward add and output buffering; its ready gates the chain
  chacha_out_skid u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pipe_valid[NUM_CELLS]),
    .data_i  (pipe_data[NUM_CELLS]),
    .ready_o (pipe_en),
    .valid_o (ks_o.valid),
    .ready_i (ks_o.ready),
    .data_o  (ks_state)
  );

  assign ks_o.out_0_1   = {ks_state[1],  ks_state[0]};
  assign ks_o.out_2_3   = {ks_state[3],  ks_state[2]};
  assign ks_o.out_4_5   = {ks_state[5],  ks_state[4]};
  assign ks_o.out_6_7   = {ks_state[7],  ks_state[6]};
  assign ks_o.out_8_9   = {ks_state[9],  ks_state[8]};
  assign ks_o.out_10_11 = {ks_state[11], ks_state[10]};
  assign ks_o.out_12_13 = {ks_state[13], ks_state[12]};
  assign ks_o.out_14_15 = {ks_state[15], ks_state[14]};

endmodule

// File: hdl/chacha_checker.sv
// Port-level checker for the ChaCha20 block function unit, bound to the top level.
`include "chacha20_block_function_unit_defines.svh"

module chacha_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         in_ready_i,
  input logic         out_valid_i,
  input logic         out_ready_i,
  input logic [511:0] out_data_i
);

  // stalled keystream beat stays up
  `CHACHA_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "out beat dropped while stalled")
  // and its payload does not move
  `CHACHA_ASSERT_NXT(a_out_stable, out_valid_i && !out_ready_i, $stable(out_data_i), "out payload changed while stalled")
  // input back-pressure only when a full beat is waiting at the output
  `CHACHA_ASSERT_IMP(a_bp_has_out, !in_ready_i, out_valid_i, "input stalled with no output beat")
  // skid slot has drained by the next cycle once the sink takes a beat
  `CHACHA_ASSERT_NXT(a_bp_release, !in_ready_i && out_ready_i, in_ready_i, "input stall outlived output drain")

endmodule

bind chacha20_block_function_unit chacha_checker u_chacha_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (blk_i.ready),
  .out_valid_i (ks_o.valid),
  .out_ready_i (ks_o.ready),
  .out_data_i  ({ks_o.out_14_15, ks_o.out_12_13, ks_o.out_10_11, ks_o.out_8_9,
                 ks_o.out_6_7, ks_o.out_4_5, ks_o.out_2_3, ks_o.out_0_1})
);

// File: bench/testbench.sv
// Self-checking bench for the ChaCha20 block function unit: directed and random blocks.
`timescale 1ns / 1ps

module testbench;
  import chacha_pkg::*;

  localparam int unsigned DOUBLE_ROUNDS = 10;
  // Cell chain plus output register; the tail wait is built on this.
  localparam int unsigned LATENCY       = 8 * DOUBLE_ROUNDS + 1;
  localparam int unsigned RANDOM_BLOCKS = 1650;
  localparam int unsigned MAX_GAP       = 10;
  localparam int unsigned DRAIN_EVERY   = 500;  // random blocks between full drains
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam int unsigned CYCLE_LIMIT   = 250000;

  // "expand 32-byte k"
  localparam word_t SIGMA [4] = '{32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574};

  typedef enum int unsigned {
    STIM_WELL_FORMED,  // real constants, random key/counter/nonce
    STIM_DENSE,        // every bit random
    STIM_SPARSE        // words of zeros, ones, single bits or random
  } stim_kind_e;

  typedef struct {
    state_t      words;
    int unsigned gap;    // idle cycles before the block is offered
    bit          drain;  // hold the block back until no keystream is outstanding
  } block_beat_t;

  logic clk_i;
  logic rst_ni;

  chacha_in_if  blk_if ();
  chacha_out_if ks_if ();

  chacha20_block_function_unit #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .blk_i  (blk_if),
    .ks_o   (ks_if)
  );

  block_beat_t blocks_to_send [$];
  state_t      keystream_due  [$];

  int unsigned beats_sent;
  int unsigned beats_received;
  int unsigned fail_count;
  int unsigned cycle_cnt;
  int unsigned drain_pauses;
  int unsigned directed_blocks;
  int unsigned kind_count [3];

  // ---------------------------------------------------------------------------
  // Predictor: RFC 8439 block function on the packed 16-word state.
  // ---------------------------------------------------------------------------
  function automatic word_t rotate_left(word_t v, int unsigned n);
    return (v << n) | (v >> (WORD_W - n));
  endfunction

  function automatic state_t chacha_block(state_t init);
    word_t       x [16];
    word_t       a, b, c, d;
    int unsigned q, sh, ia, ib, ic, id;
    state_t      ks;
    for (int k = 0; k < 16; k++) x[k] = init[k];
    for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
      // steps 0..3 work the columns, 4..7 the diagonals (rows 1..3 shifted by 1..3)
      for (int s = 0; s < 8; s++) begin
        q  = s % 4;
        sh = (s < 4) ? 0 : 1;
        ia = q;
        ib = 4  + (q + sh) % 4;
        ic = 8  + (q + 2 * sh) % 4;
        id = 12 + (q + 3 * sh) % 4;
        a = x[ia]; b = x[ib]; c = x[ic]; d = x[id];
        a = a + b; d = rotate_left(d ^ a, 16);
        c = c + d; b = rotate_left(b ^ c, 12);
        a = a + b; d = rotate_left(d ^ a, 8);
        c = c + d; b = rotate_left(b ^ c, 7);
        x[ia] = a; x[ib] = b; x[ic] = c; x[id] = d;
      end
    end
    for (int k = 0; k < 16; k++) ks[k] = x[k] + init[k];
    return ks;
  endfunction

  task automatic report_failure(string msg);
    if (fail_count < REPORT_LIMIT) $display("[%0t] ERROR: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic queue_block(state_t words, int unsigned gap, bit drain);
    block_beat_t bb;
    bb.words = words;
    bb.gap   = gap;
    bb.drain = drain;
    blocks_to_send.push_back(bb);
  endtask

  // ---------------------------------------------------------------------------
  // Clock and cycle limit
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles: %0d blocks sent, %0d keystream beats seen",
               cycle_cnt, beats_sent, beats_received);
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: offers queued blocks on blk_if. Each block waits out its own gap,
  // and a drain block also waits until every outstanding keystream has come back.
  // While valid is low the payload carries junk, which the unit must ignore.
  // ---------------------------------------------------------------------------
  block_beat_t staged;
  bit          have_staged;
  bit          offering;
  int unsigned idle_left;
  state_t      on_bus;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      blk_if.valid <= 1'b0;
      offering    = 1'b0;
      have_staged = 1'b0;
      idle_left   = 0;
    end else begin
      if (blk_if.valid && blk_if.ready) begin
        // beat taken: its keystream is due later, in order
        keystream_due.push_back(chacha_block(on_bus));
        beats_sent++;
        offering = 1'b0;
      end
      if (!offering) begin
        if (!have_staged && blocks_to_send.size() != 0) begin
          staged      = blocks_to_send.pop_front();
          have_staged = 1'b1;
          idle_left   = staged.gap;
        end
        if (have_staged && idle_left != 0) begin
          idle_left--;
        end else if (have_staged && (!staged.drain || keystream_due.size() == 0)) begin
          on_bus      = staged.words;
          offering    = 1'b1;
          have_staged = 1'b0;
          if (staged.drain) drain_pauses++;
        end
      end
      blk_if.valid <= offering;
      if (offering) begin
        blk_if.words_0_1   <= on_bus[1:0];
        blk_if.words_2_3   <= on_bus[3:2];
        blk_if.words_4_5   <= on_bus[5:4];
        blk_if.words_6_7   <= on_bus[7:6];
        blk_if.words_8_9   <= on_bus[9:8];
        blk_if.words_10_11 <= on_bus[11:10];
        blk_if.words_12_13 <= on_bus[13:12];
        blk_if.words_14_15 <= on_bus[15:14];
      end else begin
        blk_if.words_0_1   <= {$urandom, $urandom};
        blk_if.words_2_3   <= {$urandom, $urandom};
        blk_if.words_4_5   <= {$urandom, $urandom};
        blk_if.words_6_7   <= {$urandom, $urandom};
        blk_if.words_8_9   <= {$urandom, $urandom};
        blk_if.words_10_11 <= {$urandom, $urandom};
        blk_if.words_12_13 <= {$urandom, $urandom};
        blk_if.words_14_15 <= {$urandom, $urandom};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: takes keystream beats, checks each 64-bit field against the oldest
  // prediction, then stalls ready for a random count. Every 64 beats it may
  // switch to a calm stretch with ready held high.
  // ---------------------------------------------------------------------------
  int unsigned rx_stall;
  bit          rx_calm;
  string       field_name [8] = '{"out_0_1", "out_2_3", "out_4_5", "out_6_7",
                                  "out_8_9", "out_10_11", "out_12_13", "out_14_15"};

  always @(posedge clk_i) begin
    logic [511:0] want;
    logic [511:0] got;
    if (!rst_ni) begin
      ks_if.ready <= 1'b0;
      rx_stall = $urandom_range(0, MAX_GAP);
      rx_calm  = 1'b0;
    end else begin
      if (ks_if.valid && ks_if.ready) begin
        beats_received++;
        got = {ks_if.out_14_15, ks_if.out_12_13, ks_if.out_10_11, ks_if.out_8_9,
               ks_if.out_6_7, ks_if.out_4_5, ks_if.out_2_3, ks_if.out_0_1};
        if (keystream_due.size() == 0) begin
          report_failure("keystream beat with no block outstanding");
        end else begin
          want = keystream_due.pop_front();
          for (int f = 0; f < 8; f++) begin
            if (got[64*f +: 64] !== want[64*f +: 64])
              report_failure($sformatf("beat %0d %s: expected %h, got %h", beats_received,
                                       field_name[f], want[64*f +: 64], got[64*f +: 64]));
          end
        end
        if (beats_received % 64 == 0) rx_calm = ($urandom_range(0, 3) == 0);
        rx_stall = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (rx_stall != 0) begin
        rx_stall--;
        ks_if.ready <= 1'b0;
      end else begin
        ks_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  word_t       rfc_words [16] = '{32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574,
                                  32'h03020100, 32'h07060504, 32'h0b0a0908, 32'h0f0e0d0c,
                                  32'h13121110, 32'h17161514, 32'h1b1a1918, 32'h1f1e1d1c,
                                  32'h00000001, 32'h09000000, 32'h4a000000, 32'h00000000};

  initial begin
    state_t      st;
    stim_kind_e  kind;
    int unsigned pick;
    int unsigned gap;
    bit          tx_calm;

    rst_ni             = 1'b0;
    blk_if.valid       = 1'b0;
    blk_if.words_0_1   = '0;
    blk_if.words_2_3   = '0;
    blk_if.words_4_5   = '0;
    blk_if.words_6_7   = '0;
    blk_if.words_8_9   = '0;
    blk_if.words_10_11 = '0;
    blk_if.words_12_13 = '0;
    blk_if.words_14_15 = '0;
    ks_if.ready        = 1'b0;
    cycle_cnt          = 0;
    beats_sent         = 0;
    beats_received     = 0;
    fail_count         = 0;
    drain_pauses       = 0;
    tx_calm            = 1'b0;
    foreach (kind_count[k]) kind_count[k] = 0;

    // Directed blocks, back to back: bit extremes, the RFC sample state,
    // counter at wrap, and a few hand patterns.
    queue_block('0, 0, 1'b0);
    queue_block('1, 0, 1'b0);
    for (int k = 0; k < 16; k++) st[k] = rfc_words[k];
    queue_block(st, 0, 1'b0);
    queue_block({16{32'h55555555}}, 0, 1'b0);
    queue_block({16{32'haaaaaaaa}}, 0, 1'b0);
    queue_block({16{32'h80000000}}, 0, 1'b0);
    queue_block({16{32'h00000001}}, 0, 1'b0);
    queue_block({8{64'hffffffff_00000000}}, 0, 1'b0);
    queue_block({8{64'h00000000_ffffffff}}, 0, 1'b0);
    st = '0;
    for (int k = 0; k < 4; k++) st[k] = SIGMA[k];
    queue_block(st, 0, 1'b0);              // all-zero key, counter and nonce
    st = '1;
    for (int k = 0; k < 4; k++) st[k] = SIGMA[k];
    queue_block(st, 0, 1'b0);              // all-ones key, counter at its maximum
    for (int k = 0; k < 16; k++) st[k] = word_t'(k);
    queue_block(st, 0, 1'b0);
    st = '0;
    st[0] = 32'h00000001;
    queue_block(st, 0, 1'b0);              // lone low bit
    st = '0;
    st[15] = 32'h80000000;
    queue_block(st, 0, 1'b0);              // lone top bit
    directed_blocks = blocks_to_send.size();

    // Random blocks: half real-looking states, the rest dense and sparse noise.
    for (int n = 0; n < RANDOM_BLOCKS; n++) begin
      if (n % 40 == 0) tx_calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      kind = (pick < 5) ? STIM_WELL_FORMED : (pick < 8) ? STIM_DENSE : STIM_SPARSE;
      kind_count[kind]++;
      case (kind)
        STIM_WELL_FORMED: begin
          for (int k = 0; k < 16; k++) st[k] = $urandom;
          for (int k = 0; k < 4; k++) st[k] = SIGMA[k];
          case ($urandom_range(0, 3))
            0:       st[12] = 32'hffffffff - $urandom_range(0, 3);  // near counter wrap
            1:       st[12] = $urandom_range(0, 15);
            default: st[12] = $urandom;
          endcase
        end
        STIM_DENSE: begin
          for (int k = 0; k < 16; k++) st[k] = $urandom;
        end
        default: begin
          for (int k = 0; k < 16; k++) begin
            case ($urandom_range(0, 3))
              0:       st[k] = '0;
              1:       st[k] = '1;
              2:       st[k] = word_t'(1) << $urandom_range(0, WORD_W - 1);
              default: st[k] = $urandom;
            endcase
          end
        end
      endcase
      gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
      queue_block(st, gap, (n % DRAIN_EVERY) == 0);
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // every block taken, every keystream back, then a quiet tail for strays
    while (beats_sent != directed_blocks + RANDOM_BLOCKS) @(negedge clk_i);
    while (beats_received < beats_sent) @(negedge clk_i);
    repeat (2 * LATENCY) @(negedge clk_i);
    if (keystream_due.size() != 0)
      report_failure($sformatf("%0d keystream beats never arrived", keystream_due.size()));

    $display("Covered %0d directed and %0d random blocks (%0d well-formed, %0d dense, %0d sparse)",
             directed_blocks, RANDOM_BLOCKS, kind_count[STIM_WELL_FORMED],
             kind_count[STIM_DENSE], kind_count[STIM_SPARSE]);
    $display("Checked %0d keystream beats with random gaps and stalls, %0d full drains, %0d errors",
             beats_received, drain_pauses, fail_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
